/* rtl/core/ymr_pkg.sv */
// ----------------------------------------------------------------------------
// YMODEM receiver package
// Shared codes, byte values and frame phases of the YMODEM packet receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ymr_pkg;

  localparam logic [7:0] BYTE_SOH = 8'h01;
  localparam logic [7:0] BYTE_STX = 8'h02;
  localparam logic [7:0] BYTE_EOT = 8'h04;
  localparam logic [7:0] BYTE_CAN = 8'h18;

  localparam int unsigned CountWidth = 11;
  localparam logic [CountWidth-1:0] SHORT_LEN = 11'd128;
  localparam logic [CountWidth-1:0] LONG_LEN  = 11'd1024;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [7:0]  BLOCK_PREV_RESET = 8'hFF;

  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_TIMEOUT = 1'b1;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  localparam logic [2:0] V_HEADER = 3'd0;
  localparam logic [2:0] V_DATA   = 3'd1;
  localparam logic [2:0] V_DUP    = 3'd2;
  localparam logic [2:0] V_FAIL   = 3'd3;
  localparam logic [2:0] V_EOT    = 3'd4;
  localparam logic [2:0] V_CAN    = 3'd5;
  localparam logic [2:0] V_SENDC  = 3'd6;
  localparam logic [2:0] V_ABORT  = 3'd7;

  typedef enum logic [2:0] {
    PH_START,
    PH_BLOCK,
    PH_COMPL,
    PH_DATA,
    PH_CRCH,
    PH_CRCL
  } phase_e;

endpackage

/* rtl/core/ymr_in_if.sv */
// ----------------------------------------------------------------------------
// YMODEM receiver input channel
// Valid/ready channel that carries one received byte or one timeout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ymr_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] rx_byte;

  modport source (output valid, output opcode, output rx_byte, input ready);
  modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

/* rtl/core/ymr_out_if.sv */
// ----------------------------------------------------------------------------
// YMODEM receiver result channel
// Valid/ready channel that carries one payload byte or one verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ymr_out_if;
  logic       valid;
  logic       ready;
  logic       out_kind;
  logic [7:0] payload_byte;
  logic [2:0] verdict;
  logic [7:0] block_number;
  logic       long_block;

  modport source (
    output valid, output out_kind, output payload_byte, output verdict,
    output block_number, output long_block, input ready
  );
  modport sink (
    input valid, input out_kind, input payload_byte, input verdict,
    input block_number, input long_block, output ready
  );
endinterface

/* rtl/core/ymodem_packet_receiver.sv */
// ----------------------------------------------------------------------------
// YMODEM packet receiver
// A result is registered and shown in the cycle after the transfer that causes it.
// Throughput: one item per cycle unless a result waits untaken; a byte's CRC
// is updated in the same cycle; the result register frees while it is taken.
// Reset clears the frame phase, counters and flags; the last block starts
// at 255 and the receiver waits for a start byte before the handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ymodem_packet_receiver (
  input  logic     clk_i,
  input  logic     rst_ni,
  ymr_in_if.sink   rx_i,
  ymr_out_if.source res_o
);
  import ymr_pkg::*;

  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  phase_e                phase_q, phase_d;
  logic [CountWidth-1:0] count_q, count_d;
  logic [15:0]           crc_q, crc_d;
  logic [7:0]            crc_hi_q, crc_hi_d;
  logic [7:0]            block_q, block_d;
  logic [7:0]            compl_q, compl_d;
  logic [7:0]            prev_q, prev_d;
  logic                  long_q, long_d;
  logic                  started_q, started_d;
  logic                  ended_q, ended_d;

  logic                  valid_q, valid_d;
  logic                  kind_q, kind_d;
  logic [7:0]            data_q, data_d;
  logic [2:0]            verdict_q, verdict_d;
  logic [7:0]            blk_out_q, blk_out_d;
  logic                  long_out_q, long_out_d;

  logic                  accept;
  logic                  emit;
  logic [CountWidth-1:0] count_inc;
  logic [CountWidth-1:0] len;

  assign rx_i.ready = !valid_q || res_o.ready;
  assign accept     = rx_i.valid && rx_i.ready;
  assign count_inc  = count_q + 1'b1;
  assign len        = long_q ? LONG_LEN : SHORT_LEN;

  always_comb begin
    phase_d    = phase_q;
    count_d    = count_q;
    crc_d      = crc_q;
    crc_hi_d   = crc_hi_q;
    block_d    = block_q;
    compl_d    = compl_q;
    prev_d     = prev_q;
    long_d     = long_q;
    started_d  = started_q;
    ended_d    = ended_q;
    emit       = 1'b0;
    kind_d     = KIND_VERDICT;
    data_d     = 8'h00;
    verdict_d  = V_FAIL;
    blk_out_d  = block_q;
    long_out_d = long_q;

    if (accept && !ended_q) begin
      if (rx_i.opcode == OP_TIMEOUT) begin
        emit = 1'b1;
        if (phase_q == PH_START) begin
          verdict_d  = started_q ? V_FAIL : V_SENDC;
          blk_out_d  = 8'h00;
          long_out_d = 1'b0;
        end else begin
          phase_d = PH_START;
        end
      end else begin
        unique case (phase_q)
          PH_START: begin
            blk_out_d  = 8'h00;
            long_out_d = 1'b0;
            if (rx_i.rx_byte == BYTE_SOH || rx_i.rx_byte == BYTE_STX) begin
              long_d   = (rx_i.rx_byte == BYTE_STX);
              count_d  = '0;
              crc_d    = 16'h0000;
              crc_hi_d = 8'h00;
              block_d  = 8'h00;
              compl_d  = 8'h00;
              phase_d  = PH_BLOCK;
            end else if (rx_i.rx_byte == BYTE_EOT) begin
              emit      = 1'b1;
              verdict_d = V_EOT;
            end else if (rx_i.rx_byte == BYTE_CAN) begin
              emit      = 1'b1;
              verdict_d = V_CAN;
            end else begin
              emit      = 1'b1;
              verdict_d = V_FAIL;
            end
          end
          PH_BLOCK: begin
            block_d = rx_i.rx_byte;
            phase_d = PH_COMPL;
          end
          PH_COMPL: begin
            compl_d = rx_i.rx_byte;
            phase_d = PH_DATA;
          end
          PH_DATA: begin
            crc_d     = crc_step(crc_q, rx_i.rx_byte);
            count_d   = count_inc;
            if (count_inc >= len) begin
              phase_d = PH_CRCH;
            end
            emit      = 1'b1;
            kind_d    = KIND_PAYLOAD;
            data_d    = rx_i.rx_byte;
            verdict_d = V_HEADER;
          end
          PH_CRCH: begin
            crc_hi_d = rx_i.rx_byte;
            phase_d  = PH_CRCL;
          end
          PH_CRCL: begin
            phase_d = PH_START;
            emit    = 1'b1;
            if (crc_q != {crc_hi_q, rx_i.rx_byte}) begin
              verdict_d = V_FAIL;
            end else if ((block_q ^ 8'hFF) != compl_q) begin
              verdict_d = V_FAIL;
            end else if (block_q == prev_q) begin
              verdict_d = V_DUP;
            end else if (block_q != prev_q + 8'd1) begin
              verdict_d = V_FAIL;
            end else begin
              prev_d = block_q;
              if (started_q) begin
                verdict_d = V_DATA;
              end else if (block_q == 8'h00 && !long_q) begin
                started_d = 1'b1;
                verdict_d = V_HEADER;
              end else begin
                ended_d   = 1'b1;
                verdict_d = V_ABORT;
              end
            end
          end
          default: begin
            phase_d = PH_START;
          end
        endcase
      end
    end

    if (accept) begin
      valid_d = emit;
    end else begin
      valid_d = valid_q && !res_o.ready;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_START;
      count_q   <= '0;
      crc_q     <= 16'h0000;
      crc_hi_q  <= 8'h00;
      block_q   <= 8'h00;
      compl_q   <= 8'h00;
      prev_q    <= BLOCK_PREV_RESET;
      long_q    <= 1'b0;
      started_q <= 1'b0;
      ended_q   <= 1'b0;
      valid_q   <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      count_q   <= count_d;
      crc_q     <= crc_d;
      crc_hi_q  <= crc_hi_d;
      block_q   <= block_d;
      compl_q   <= compl_d;
      prev_q    <= prev_d;
      long_q    <= long_d;
      started_q <= started_d;
      ended_q   <= ended_d;
      valid_q   <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      kind_q     <= kind_d;
      data_q     <= data_d;
      verdict_q  <= verdict_d;
      blk_out_q  <= blk_out_d;
      long_out_q <= long_out_d;
    end
  end

  assign res_o.valid        = valid_q;
  assign res_o.out_kind     = kind_q;
  assign res_o.payload_byte = data_q;
  assign res_o.verdict      = verdict_q;
  assign res_o.block_number = blk_out_q;
  assign res_o.long_block   = long_out_q;

endmodule

/* rtl/core/ymr_checker.sv */
// ----------------------------------------------------------------------------
// YMODEM receiver port checker
// Watches the ports of the receiver for channel and sequencing errors.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ymr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       out_kind_i,
  input logic [7:0] payload_byte_i,
  input logic [2:0] verdict_i,
  input logic [7:0] block_number_i,
  input logic       long_block_i
);
  import ymr_pkg::*;

  logic in_xfer;
  logic out_xfer;

  assign in_xfer  = in_valid_i && in_ready_i;
  assign out_xfer = out_valid_i && out_ready_i;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result valid dropped before its transfer");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_kind_i) && $stable(payload_byte_i)
      && $stable(verdict_i) && $stable(block_number_i) && $stable(long_block_i))
    else $error("stalled result changed");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without a waiting result");

  a_result_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !$past(out_valid_i) |-> $past(in_xfer))
    else $error("result appeared without an input transfer");

  a_abort_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && out_kind_i == KIND_VERDICT && verdict_i == V_ABORT |=> !out_valid_i)
    else $error("result after abort");

endmodule

bind ymodem_packet_receiver ymr_checker u_ymr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (rx_i.valid),
  .in_ready_i     (rx_i.ready),
  .out_valid_i    (res_o.valid),
  .out_ready_i    (res_o.ready),
  .out_kind_i     (res_o.out_kind),
  .payload_byte_i (res_o.payload_byte),
  .verdict_i      (res_o.verdict),
  .block_number_i (res_o.block_number),
  .long_block_i   (res_o.long_block)
);
